@@ rtl/msgfrag_pkg.sv @@
// shared types and constants of the message fragmenter
package msgfrag_pkg;

  // input transaction payload
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [31:0] message_length;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       fragment_end;
    logic       message_end;
    logic       run_last;
  } out_item_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HDR,
    ST_PAY
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic hdr_step;
    logic pay_step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_message;
    logic room_zero;
    logic div_done;
    logic hdr_last;
    logic out_free;
  } status_t;

  // configuration register indexes
  localparam logic REG_MAX_SIZE = 1'b0;
  localparam logic REG_MSG_NUM  = 1'b1;

  // register reset values
  localparam logic [15:0] MAX_SIZE_RST = 16'd4096;
  localparam logic [31:0] MSG_NUM_RST  = 32'd0;

  // fragment size floor and header lengths
  localparam logic [15:0] MIN_FRAG      = 16'd13;
  localparam logic [15:0] HDR_SHORT_LEN = 16'd8;
  localparam logic [15:0] HDR_LONG_LEN  = 16'd12;
  localparam logic [32:0] COUNT_WORD_LEN = 33'd4;

  // divider sizing: numerator len + 4 + div - 1 fits in 33 bits
  localparam int NUM_W  = 33;
  localparam int DIV_W  = 16;
  localparam int STEP_W = $clog2(NUM_W);

endpackage

@@ rtl/msgfrag_div.sv @@
// restoring radix-2 divider for the fragment count, one quotient bit per cycle
module msgfrag_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [msgfrag_pkg::NUM_W-1:0]  numer,
  input  logic [msgfrag_pkg::DIV_W-1:0]  denom,
  output logic                           done,
  output logic [31:0]                    quot
);

  logic                              busy_r;
  logic                              done_r;
  logic [msgfrag_pkg::STEP_W-1:0]    step_r;
  logic [msgfrag_pkg::NUM_W-1:0]     num_r;
  logic [msgfrag_pkg::DIV_W-1:0]     rem_r;
  logic [msgfrag_pkg::DIV_W-1:0]     den_r;
  logic [msgfrag_pkg::DIV_W:0]       trial;
  logic                              q_bit;
  logic                              last_step;

  // trial subtract of the shifted remainder
  always_comb begin
    trial     = {rem_r, num_r[msgfrag_pkg::NUM_W-1]};
    q_bit     = (trial >= {1'b0, den_r});
    last_step = (step_r == msgfrag_pkg::STEP_W'(msgfrag_pkg::NUM_W - 1));
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (last_step) busy_r <= 1'b0;
        step_r <= step_r + 1'b1;
      end
    end
  end

  // datapath: quotient bits shift in at the bottom of the numerator
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      rem_r <= '0;
      den_r <= denom;
    end else if (busy_r) begin
      num_r <= {num_r[msgfrag_pkg::NUM_W-2:0], q_bit};
      rem_r <= q_bit ? msgfrag_pkg::DIV_W'(trial - {1'b0, den_r})
                     : trial[msgfrag_pkg::DIV_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = num_r[31:0];

endmodule

@@ rtl/msgfrag_dp.sv @@
// datapath: config registers, message state, header bytes and output register
module msgfrag_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  msgfrag_pkg::in_item_t   in_data,
  input  logic                    out_stall,
  output logic                    out_valid,
  output msgfrag_pkg::out_item_t  out_data,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [31:0]             cfg_wdata,
  input  msgfrag_pkg::cmd_t       cmd,
  output msgfrag_pkg::status_t    status
);

  logic [15:0] max_size_r;
  logic [31:0] msg_num_r;
  logic        in_message_r;
  logic [31:0] bytes_left_r;
  logic [31:0] frag_index_r;
  logic [31:0] frags_total_r;
  logic [15:0] frag_room_r;
  logic [7:0]  byte_r;
  logic [3:0]  hdr_cnt_r;
  logic        out_valid_r;
  msgfrag_pkg::out_item_t out_r;

  logic [15:0] eff_max;
  logic [15:0] div_size;
  logic [31:0] len_eff;
  logic [msgfrag_pkg::NUM_W-1:0] numer;
  logic        div_done;
  logic [31:0] div_quot;
  logic [15:0] hdr_len;
  logic        hdr_last;
  logic [31:0] hdr_word;
  logic [7:0]  hdr_byte;
  logic        msg_end;
  logic        frag_end;
  logic        out_free;

  // effective fragment size and count numerator
  always_comb begin
    eff_max  = (max_size_r < msgfrag_pkg::MIN_FRAG) ? msgfrag_pkg::MIN_FRAG : max_size_r;
    div_size = eff_max - msgfrag_pkg::HDR_SHORT_LEN;
    len_eff  = (in_data.message_length == 32'd0) ? 32'd1 : in_data.message_length;
    numer    = {1'b0, len_eff} + msgfrag_pkg::COUNT_WORD_LEN
             + {17'b0, div_size} - 33'd1;
  end

  msgfrag_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.accept && !in_message_r),
    .numer (numer),
    .denom (div_size),
    .done  (div_done),
    .quot  (div_quot)
  );

  // header byte selection
  always_comb begin
    hdr_len  = (frag_index_r == 32'd1) ? msgfrag_pkg::HDR_LONG_LEN
                                       : msgfrag_pkg::HDR_SHORT_LEN;
    hdr_last = ({12'b0, hdr_cnt_r} == hdr_len - 16'd1);
    unique case (hdr_cnt_r[3:2])
      2'd0:    hdr_word = msg_num_r;
      2'd1:    hdr_word = frag_index_r;
      default: hdr_word = frags_total_r;
    endcase
    hdr_byte = hdr_word[{hdr_cnt_r[1:0], 3'b000} +: 8];
  end

  // payload byte flags
  always_comb begin
    msg_end  = (bytes_left_r == 32'd1);
    frag_end = msg_end || (frag_room_r == 16'd1);
    out_free = !out_valid_r || !out_stall;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= msgfrag_pkg::MAX_SIZE_RST;
      msg_num_r  <= msgfrag_pkg::MSG_NUM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msgfrag_pkg::REG_MAX_SIZE: max_size_r <= cfg_wdata[15:0];
        msgfrag_pkg::REG_MSG_NUM:  msg_num_r  <= cfg_wdata;
      endcase
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_message_r  <= 1'b0;
      bytes_left_r  <= '0;
      frag_index_r  <= 32'd1;
      frags_total_r <= '0;
      frag_room_r   <= '0;
      hdr_cnt_r     <= '0;
    end else begin
      if (cmd.accept && !in_message_r) begin
        in_message_r <= 1'b1;
        bytes_left_r <= len_eff;
        frag_index_r <= 32'd1;
        frag_room_r  <= '0;
      end
      if (div_done) frags_total_r <= div_quot;
      if (cmd.hdr_step) begin
        hdr_cnt_r <= hdr_last ? 4'd0 : hdr_cnt_r + 4'd1;
        if (hdr_last) frag_room_r <= eff_max - hdr_len;
      end
      if (cmd.pay_step) begin
        bytes_left_r <= bytes_left_r - 32'd1;
        frag_room_r  <= frag_end ? 16'd0 : frag_room_r - 16'd1;
        if (msg_end) begin
          in_message_r <= 1'b0;
          frag_index_r <= 32'd1;
        end else if (frag_end) begin
          frag_index_r <= frag_index_r + 32'd1;
        end
      end
    end
  end

  // item byte latch
  always_ff @(posedge clk) begin
    if (cmd.accept) byte_r <= in_data.payload_byte;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.hdr_step || cmd.pay_step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_step) begin
      out_r.out_byte     <= hdr_byte;
      out_r.fragment_end <= 1'b0;
      out_r.message_end  <= 1'b0;
      out_r.run_last     <= 1'b0;
    end else if (cmd.pay_step) begin
      out_r.out_byte     <= byte_r;
      out_r.fragment_end <= frag_end;
      out_r.message_end  <= msg_end;
      out_r.run_last     <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status to controller
  always_comb begin
    status.in_message = in_message_r;
    status.room_zero  = (frag_room_r == 16'd0);
    status.div_done   = div_done;
    status.hdr_last   = hdr_last;
    status.out_free   = out_free;
  end

endmodule

@@ rtl/msgfrag_ctrl.sv @@
// controller state machine sequencing accept, count division, header and payload
module msgfrag_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  msgfrag_pkg::status_t  status,
  output msgfrag_pkg::cmd_t     cmd
);

  msgfrag_pkg::state_t state_r;
  msgfrag_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msgfrag_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msgfrag_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!status.in_message)    state_nxt = msgfrag_pkg::ST_DIV;
          else if (status.room_zero) state_nxt = msgfrag_pkg::ST_HDR;
          else                       state_nxt = msgfrag_pkg::ST_PAY;
        end
      end
      msgfrag_pkg::ST_DIV: begin
        if (status.div_done) state_nxt = msgfrag_pkg::ST_HDR;
      end
      msgfrag_pkg::ST_HDR: begin
        if (status.out_free && status.hdr_last) state_nxt = msgfrag_pkg::ST_PAY;
      end
      msgfrag_pkg::ST_PAY: begin
        if (status.out_free) state_nxt = msgfrag_pkg::ST_IDLE;
      end
      default: state_nxt = msgfrag_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall     = (state_r != msgfrag_pkg::ST_IDLE);
    cmd.accept   = (state_r == msgfrag_pkg::ST_IDLE) && in_valid;
    cmd.hdr_step = (state_r == msgfrag_pkg::ST_HDR) && status.out_free;
    cmd.pay_step = (state_r == msgfrag_pkg::ST_PAY) && status.out_free;
  end

endmodule

@@ rtl/message_fragmenter.sv @@
// top level of the message fragmenter: controller, datapath and checks
// a byte in an open fragment goes from the accept via the payload state to the output
//   register, held while the output stalls; one that opens a later fragment adds 8
//   header bytes, the first of a message the bit-serial divider and 12 header bytes
// one item at a time: in_stall holds until its payload byte enters the output register
// reset (synchronous, rst_n low): idle, no message open, registers back to 4096 and 0
module message_fragmenter (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  msgfrag_pkg::in_item_t   in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output msgfrag_pkg::out_item_t  out_data,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [31:0]             cfg_wdata
);

  msgfrag_pkg::cmd_t    cmd;
  msgfrag_pkg::status_t status;

  // sequencing
  msgfrag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // message state and byte path
  msgfrag_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

  // one transaction at a time: stall rises right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // header bytes carry no end flags
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_last |-> !out_data.fragment_end && !out_data.message_end)
    else $error("end flag on a header byte");

  // message end always closes the fragment
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.message_end |-> out_data.fragment_end)
    else $error("message end without fragment end");

  // accept, header and payload steps never overlap
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.hdr_step, cmd.pay_step}))
    else $error("controller issued overlapping commands");

endmodule

@@ tb/tb_message_fragmenter.sv @@
// self-checking testbench of the message fragmenter with a built-in fragment predictor
module tb_message_fragmenter;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  msgfrag_pkg::in_item_t  in_data;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  msgfrag_pkg::out_item_t out_data;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [31:0]            cfg_wdata;

  message_fragmenter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of registers and fragmenting state
  logic [15:0] frag_limit = msgfrag_pkg::MAX_SIZE_RST;
  logic [31:0] msg_id     = msgfrag_pkg::MSG_NUM_RST;
  logic        msg_open   = 1'b0;
  logic [31:0] left_count = '0;
  logic [31:0] frag_idx   = 32'd1;
  logic [31:0] frag_count = '0;
  logic [15:0] room_left  = '0;

  msgfrag_pkg::out_item_t expected_bytes[$];
  msgfrag_pkg::out_item_t want;
  int          fail_count     = 0;
  int          items_sent     = 0;
  int          bytes_checked  = 0;
  int          messages_done  = 0;
  int          burst_left     = 0;

  // receiver pattern state
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;
  int unsigned cyc        = 0;

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // header word, little-endian, never flagged as an end
  task automatic push_word(input logic [31:0] w);
    msgfrag_pkg::out_item_t hb;
    for (int i = 0; i < 4; i++) begin
      hb.out_byte     = w[8*i +: 8];
      hb.fragment_end = 1'b0;
      hb.message_end  = 1'b0;
      hb.run_last     = 1'b0;
      expected_bytes.push_back(hb);
    end
  endtask

  // expected output bytes for one accepted input transaction
  task automatic predict_fragment_bytes(input msgfrag_pkg::in_item_t item);
    logic [31:0] len;
    logic [63:0] span;
    logic [15:0] lim;
    logic        fe, me;
    msgfrag_pkg::out_item_t pay;
    lim = (frag_limit < msgfrag_pkg::MIN_FRAG) ? msgfrag_pkg::MIN_FRAG : frag_limit;
    // message start: length, fragment count
    if (!msg_open) begin
      len        = (item.message_length == 32'd0) ? 32'd1 : item.message_length;
      span       = 64'(lim) - 64'(msgfrag_pkg::HDR_SHORT_LEN);
      left_count = len;
      frag_count = 32'((64'(len) + 64'(msgfrag_pkg::COUNT_WORD_LEN) + span - 64'd1) / span);
      frag_idx   = 32'd1;
      room_left  = '0;
      msg_open   = 1'b1;
    end
    // header ahead of the byte that opens a fragment
    if (room_left == 16'd0) begin
      push_word(msg_id);
      push_word(frag_idx);
      if (frag_idx == 32'd1) push_word(frag_count);
      room_left = lim - ((frag_idx == 32'd1) ? msgfrag_pkg::HDR_LONG_LEN
                                             : msgfrag_pkg::HDR_SHORT_LEN);
    end
    left_count = left_count - 32'd1;
    room_left  = room_left - 16'd1;
    me = (left_count == 32'd0);
    fe = me || (room_left == 16'd0);
    pay.out_byte     = item.payload_byte;
    pay.fragment_end = fe;
    pay.message_end  = me;
    pay.run_last     = 1'b1;
    expected_bytes.push_back(pay);
    if (fe) begin
      room_left = '0;
      frag_idx  = frag_idx + 32'd1;
    end
    if (me) begin
      msg_open = 1'b0;
      frag_idx = 32'd1;
    end
  endtask

  // one input transaction, with bursts and gaps on the sender side
  task automatic send_byte(input logic [7:0] b, input logic [31:0] len);
    msgfrag_pkg::in_item_t item;
    item.payload_byte   = b;
    item.message_length = len;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_fragment_bytes(item);
    burst_left = burst_left - 1;
    items_sent = items_sent + 1;
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == msgfrag_pkg::REG_MAX_SIZE) frag_limit = val[15:0];
    else if (idx == msgfrag_pkg::REG_MSG_NUM) msg_id = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and wait for every expected byte
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // whole message of random bytes
  task automatic send_message(input logic [31:0] len);
    int n;
    n = (len == 32'd0) ? 1 : int'(len);
    for (int k = 0; k < n; k++)
      send_byte(8'($urandom), (k == 0) ? len : $urandom);
  endtask

  // reset register values, zero length and a short message
  task automatic test_defaults_and_zero_length();
    send_byte(8'hFF, 32'd0);
    send_byte(8'h00, 32'd3);
    send_byte(8'h80, 32'hFFFF_FFFF);
    send_byte(8'h7F, 32'h0000_0000);
    wait_for_drain();
  endtask

  // sizes under the floor behave as the smallest fragment
  task automatic test_size_floor();
    write_reg(msgfrag_pkg::REG_MAX_SIZE, 32'h0000_0000);
    write_reg(msgfrag_pkg::REG_MSG_NUM, 32'h0000_0001);
    send_message(32'd2);
    wait_for_drain();
    // upper write bits are beyond the register
    write_reg(msgfrag_pkg::REG_MAX_SIZE, 32'hFFFF_000C);
    send_message(32'd3);
    wait_for_drain();
  endtask

  // largest size and all-ones message number
  task automatic test_field_extremes();
    write_reg(msgfrag_pkg::REG_MAX_SIZE, 32'h0000_FFFF);
    write_reg(msgfrag_pkg::REG_MSG_NUM, 32'hFFFF_FFFF);
    send_byte(8'hFF, 32'd3);
    send_byte(8'h00, 32'd0);
    send_byte(8'h55, 32'hAAAA_5555);
    wait_for_drain();
  endtask

  // size change lands at the next header, number read at each header
  task automatic test_config_mid_message();
    write_reg(msgfrag_pkg::REG_MAX_SIZE, 32'd14);
    write_reg(msgfrag_pkg::REG_MSG_NUM, 32'h0000_0102);
    send_byte(8'h11, 32'd12);
    for (int k = 0; k < 4; k++) send_byte(8'($urandom), $urandom);
    wait_for_drain();
    write_reg(msgfrag_pkg::REG_MAX_SIZE, 32'd13);
    write_reg(msgfrag_pkg::REG_MSG_NUM, 32'hCAFE_F00D);
    for (int k = 0; k < 7; k++) send_byte(8'($urandom), $urandom);
    wait_for_drain();
  endtask

  // phases of random settings, each with a few random messages
  task automatic test_random_messages(input int item_budget);
    int          start;
    logic [15:0] lim;
    logic [31:0] len;
    start = items_sent;
    while (items_sent - start < item_budget) begin
      case ($urandom_range(0, 9))
        6:       lim = 16'($urandom_range(0, 12));
        7:       lim = 16'($urandom_range(41, 300));
        8:       lim = 16'hFFFF;
        9:       lim = 16'($urandom_range(0, 65535));
        default: lim = 16'($urandom_range(13, 40));
      endcase
      write_reg(msgfrag_pkg::REG_MAX_SIZE, {16'($urandom), lim});
      case ($urandom_range(0, 5))
        0:       write_reg(msgfrag_pkg::REG_MSG_NUM, 32'h0000_0000);
        1:       write_reg(msgfrag_pkg::REG_MSG_NUM, 32'hFFFF_FFFF);
        default: write_reg(msgfrag_pkg::REG_MSG_NUM, $urandom);
      endcase
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 19))
          0:       len = 32'd0;
          1, 2:    len = $urandom_range(41, 120);
          default: len = $urandom_range(1, 40);
        endcase
        send_message(len);
      end
      wait_for_drain();
    end
  endtask

  // length near the top of its range, count word past 32 bits of numerator
  task automatic test_length_overflow();
    write_reg(msgfrag_pkg::REG_MAX_SIZE, 32'd13);
    write_reg(msgfrag_pkg::REG_MSG_NUM, 32'h5A5A_A5A5);
    send_byte(8'h3C, 32'hFFFF_FFFF);
    for (int k = 0; k < 6; k++) send_byte(8'($urandom), $urandom);
    wait_for_drain();
  endtask

  // receiver stall pattern, switching mode every so often
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(32, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cyc % 3 == 0);
    endcase
  end

  // compare each result transaction with the oldest expected byte
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      bytes_checked <= bytes_checked + 1;
      if (expected_bytes.size() == 0) begin
        fail_count = fail_count + 1;
        $display("%0t: unexpected output byte %02h fe %0b me %0b rl %0b", $time,
                 out_data.out_byte, out_data.fragment_end, out_data.message_end,
                 out_data.run_last);
      end else begin
        want = expected_bytes.pop_front();
        if (want.message_end) messages_done <= messages_done + 1;
        if (out_data.out_byte !== want.out_byte) begin
          fail_count = fail_count + 1;
          $display("%0t: out_byte expected %02h actual %02h", $time,
                   want.out_byte, out_data.out_byte);
        end
        if (out_data.fragment_end !== want.fragment_end) begin
          fail_count = fail_count + 1;
          $display("%0t: fragment_end expected %0b actual %0b", $time,
                   want.fragment_end, out_data.fragment_end);
        end
        if (out_data.message_end !== want.message_end) begin
          fail_count = fail_count + 1;
          $display("%0t: message_end expected %0b actual %0b", $time,
                   want.message_end, out_data.message_end);
        end
        if (out_data.run_last !== want.run_last) begin
          fail_count = fail_count + 1;
          $display("%0t: run_last expected %0b actual %0b", $time,
                   want.run_last, out_data.run_last);
        end
      end
    end
  end

  // test sequence
  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= msgfrag_pkg::REG_MAX_SIZE;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults_and_zero_length();
    test_size_floor();
    test_field_extremes();
    test_config_mid_message();
    test_random_messages(220);
    test_length_overflow();

    // trailing quiet time to catch stray output transactions
    repeat (60) @(posedge clk);
    $display("covered %0d input transactions, %0d output bytes, %0d whole messages",
             items_sent, bytes_checked, messages_done);
    $display("sizes from below the floor to 65535, mid-message writes, length overflow");
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d bytes outstanding", expected_bytes.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
